FILE: rtl/fm64_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fm64_pkg
// shared types, constants and round helper functions for the 64-bit mixer
// ---------------------------------------------------------------------------
package fm64_pkg;

    typedef logic [31:0] t_half;

    typedef struct packed {
        logic  valid;
        t_half left;
        t_half right;
    } t_beat;

    localparam int unsigned NUM_ROUNDS = 4;

    localparam logic REG_MIX_MODE = 1'b0;
    localparam logic MODE_JENKINS = 1'b0;
    localparam logic MODE_PSDES   = 1'b1;

    localparam t_half JEN_K0 = 32'h7ed55d16;
    localparam t_half JEN_K1 = 32'hc761c23c;
    localparam t_half JEN_K2 = 32'h165667b1;
    localparam t_half JEN_K3 = 32'hd3a2646c;
    localparam t_half JEN_K4 = 32'hfd7046c5;
    localparam t_half JEN_K5 = 32'hb55a4f09;

    function automatic t_half jen_front(input t_half a_in);
        t_half a;
        a = a_in;
        a = (a + JEN_K0) + (a << 12);
        a = (a ^ JEN_K1) ^ (a >> 19);
        a = (a + JEN_K2) + (a << 5);
        return a;
    endfunction

    function automatic t_half jen_back(input t_half a_in);
        t_half a;
        a = a_in;
        a = (a + JEN_K3) ^ (a << 9);
        a = (a + JEN_K4) + (a << 3);
        a = (a ^ JEN_K5) ^ (a >> 16);
        return a;
    endfunction

    function automatic t_half psdes_c1(input logic [1:0] idx);
        t_half c;
        case (idx)
            2'd0: c = 32'hbaa96887;
            2'd1: c = 32'h1e17d32c;
            2'd2: c = 32'h03bcdc3c;
            default: c = 32'h0f33d1b2;
        endcase
        return c;
    endfunction

    function automatic t_half psdes_c2(input logic [1:0] idx);
        t_half c;
        case (idx)
            2'd0: c = 32'h4b0f3b58;
            2'd1: c = 32'he874f0c3;
            2'd2: c = 32'h6955c5a6;
            default: c = 32'h55a7ca46;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/feistel_mix64.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// feistel_mix64
// four-round feistel mixer of a 64-bit word with selectable round function
// ---------------------------------------------------------------------------
// two register stages per round, stage a then stage b, from input beat to output beat
// throughput: one beat per cycle; a stall holds the pipe, empty stages still fill
// the last round's second stage is the output register
// reset: synchronous active low, empties the pipe and sets mix_mode to 1
module feistel_mix64 import fm64_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_word_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_word_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic  w_mix_mode;
    t_beat w_beat  [NUM_ROUNDS+1];
    logic  w_ready [NUM_ROUNDS+1];

    fm64_apb u_apb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_mix_mode (w_mix_mode)
    );

    assign w_beat[0].valid = i_valid;
    assign w_beat[0].left  = i_word_in[31:0];
    assign w_beat[0].right = i_word_in[63:32];
    assign w_ready[NUM_ROUNDS] = !i_stall;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        fm64_round #(
            .RND (2'(g))
        ) u_round (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_mix_mode (w_mix_mode),
            .i_beat     (w_beat[g]),
            .o_ready    (w_ready[g]),
            .o_beat     (w_beat[g+1]),
            .i_ready    (w_ready[g+1])
        );
    end

    assign o_stall    = !w_ready[0];
    assign o_valid    = w_beat[NUM_ROUNDS].valid;
    assign o_word_out = {w_beat[NUM_ROUNDS].right, w_beat[NUM_ROUNDS].left};

endmodule

FILE: rtl/fm64_apb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fm64_apb
// configuration register file holding the round function select
// ---------------------------------------------------------------------------
module fm64_apb import fm64_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        o_mix_mode
);

    logic r_mix_mode;
    logic n_mix_mode;
    logic w_wr;

    assign w_wr = psel && penable && pwrite && (paddr[2] == REG_MIX_MODE);

    always_comb begin
        n_mix_mode = r_mix_mode;
        if (w_wr) begin
            n_mix_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_mode <= MODE_PSDES;
        end else begin
            r_mix_mode <= n_mix_mode;
        end
    end

    assign prdata     = (paddr[2] == REG_MIX_MODE) ? {31'b0, r_mix_mode} : 32'b0;
    assign pready     = 1'b1;
    assign o_mix_mode = r_mix_mode;

endmodule

FILE: rtl/fm64_round.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fm64_round
// one feistel round over two register stages: products and hash front half,
// then round function finish, xor into left word and swap
// ---------------------------------------------------------------------------
module fm64_round import fm64_pkg::*; #(
    parameter logic [1:0] RND = 2'd0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_mix_mode,
    input  t_beat i_beat,
    output logic  o_ready,
    output t_beat o_beat,
    input  logic  i_ready
);

    // stage a
    logic          r_a_valid;
    t_half         r_a_left;
    t_half         r_a_right;
    t_half         r_a_ll;
    t_half         r_a_hh;
    t_half         r_a_lh;
    t_half         r_a_jen;
    // stage b
    logic          r_b_valid;
    t_half         r_b_left;
    t_half         r_b_right;

    logic          w_ready_a;
    logic          w_ready_b;
    t_half         w_a;
    logic [15:0]   w_lo;
    logic [15:0]   w_hi;
    t_half         w_ll;
    t_half         w_hh;
    t_half         w_lh;
    t_half         w_b;
    t_half         w_s;
    t_half         w_f_psdes;
    t_half         w_f_jen;
    t_half         w_f;

    assign w_ready_b = !r_b_valid || i_ready;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    assign w_a  = i_beat.right ^ psdes_c1(RND);
    assign w_lo = w_a[15:0];
    assign w_hi = w_a[31:16];
    assign w_ll = 32'(w_lo) * 32'(w_lo);
    assign w_hh = 32'(w_hi) * 32'(w_hi);
    assign w_lh = 32'(w_lo) * 32'(w_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ready_a) begin
            r_a_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a) begin
            r_a_left  <= i_beat.left;
            r_a_right <= i_beat.right;
            r_a_ll    <= w_ll;
            r_a_hh    <= w_hh;
            r_a_lh    <= w_lh;
            r_a_jen   <= jen_front(i_beat.right);
        end
    end

    assign w_b       = r_a_ll + ~r_a_hh;
    assign w_s       = {w_b[15:0], w_b[31:16]};
    assign w_f_psdes = (w_s ^ psdes_c2(RND)) + r_a_lh;
    assign w_f_jen   = jen_back(r_a_jen);
    assign w_f       = (i_mix_mode == MODE_PSDES) ? w_f_psdes : w_f_jen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_b) begin
            r_b_left  <= r_a_right;
            r_b_right <= r_a_left ^ w_f;
        end
    end

    assign o_beat.valid = r_b_valid;
    assign o_beat.left  = r_b_left;
    assign o_beat.right = r_b_right;

endmodule

FILE: rtl/fm64_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fm64_chk
// port-level checks for the mixer, bound to the top level
// ---------------------------------------------------------------------------
module fm64_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [63:0] i_word_in,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_word_out,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // an empty output stage means the whole pipe can take a beat
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output stage empty");

    // held output beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word_out))
        else $error("stalled output beat changed or dropped");

    // held input beat stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_word_in))
        else $error("stalled input beat changed or dropped");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat valid after reset");

    // a mode write reads back on the next cycle
    a_mode_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && !paddr[2] |=>
            (paddr[2] || prdata == {31'b0, $past(pwdata[0])}))
        else $error("mix mode readback mismatch");

endmodule

bind feistel_mix64 fm64_chk u_fm64_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_word_in  (i_word_in),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_word_out (o_word_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);

FILE: sim/feistel_mix64_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// feistel_mix64_chk
// watches the word channels and the register port of feistel_mix64, follows
// the mix mode through register writes, works out the mixed word for every
// input beat and compares each output beat against the oldest pending word
// ---------------------------------------------------------------------------
module feistel_mix64_chk import fm64_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [63:0] i_word_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_word_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    // per-round key pairs of the multiply round, round 0 in the low bits
    localparam logic [127:0] XOR_KEYS = 128'h0f33d1b2_03bcdc3c_1e17d32c_baa96887;
    localparam logic [127:0] ADD_KEYS = 128'h55a7ca46_6955c5a6_e874f0c3_4b0f3b58;

    logic [63:0] expected_words[$];
    logic        mode;
    int          fails;

    function automatic logic [31:0] int_hash(input logic [31:0] v);
        logic [31:0] a;
        a = v;
        a = (a + 32'h7ed55d16) + (a << 12);
        a = (a ^ 32'hc761c23c) ^ (a >> 19);
        a = (a + 32'h165667b1) + (a << 5);
        a = (a + 32'hd3a2646c) ^ (a << 9);
        a = (a + 32'hfd7046c5) + (a << 3);
        a = (a ^ 32'hb55a4f09) ^ (a >> 16);
        return a;
    endfunction

    function automatic logic [31:0] mult_round(input logic [31:0] r, input int unsigned rnd);
        logic [31:0] a;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] b;
        logic [31:0] s;
        a  = r ^ XOR_KEYS[32*rnd +: 32];
        lo = {16'h0, a[15:0]};
        hi = {16'h0, a[31:16]};
        b  = (lo * lo) + ~(hi * hi);
        s  = {b[15:0], b[31:16]};
        return (s ^ ADD_KEYS[32*rnd +: 32]) + (lo * hi);
    endfunction

    function automatic logic [63:0] feistel_mix(input logic [63:0] w, input logic m);
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] f;
        logic [31:0] t;
        l = w[31:0];
        r = w[63:32];
        for (int unsigned rnd = 0; rnd < NUM_ROUNDS; rnd++) begin
            f = (m == MODE_PSDES) ? mult_round(r, rnd) : int_hash(r);
            t = r;
            r = l ^ f;
            l = t;
        end
        return {r, l};
    endfunction

    initial begin
        mode         = MODE_PSDES;
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (!i_rst_n) begin
            expected_words.delete();
            mode = MODE_PSDES;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("word_out beat with nothing pending: actual %h", i_word_out);
                    fails++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_word_out !== want) begin
                        $error("word_out mismatch: expected %h, actual %h", want, i_word_out);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(feistel_mix(i_word_in, mode));
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_MIX_MODE) begin
                if (i_pwrite) begin
                    mode = i_pwdata[0];
                end else if (i_prdata !== {31'h0, mode}) begin
                    $error("mix_mode readback mismatch: expected %h, actual %h",
                           {31'h0, mode}, i_prdata);
                    fails++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_words.size();
    end

endmodule

FILE: sim/tb_feistel_mix64.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_feistel_mix64
// drives feistel_mix64 with edge-case words in both mix modes, then phases of
// random words under changing mode settings, with random input gaps and random
// output stall outside the quiet phases; the checker reports mismatches
// ---------------------------------------------------------------------------
module tb_feistel_mix64;
    import fm64_pkg::*;

    localparam logic [2:0] ADDR_MIX_MODE = {REG_MIX_MODE, 2'b00};
    localparam logic [2:0] ADDR_UNUSED   = 3'd4;
    localparam int         PHASES        = 6;
    localparam int         PHASE_BEATS   = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_word_in;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_word_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int stall_left;
    bit tx_quiet;
    bit rx_quiet;

    logic [63:0] edge_words[12] = '{
        64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
        64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000,
        64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'h0000_0001_8000_0000, 64'h5555_5555_5555_5555,
        64'haaaa_aaaa_aaaa_aaaa, 64'h0123_4567_89ab_cdef,
        64'hbaa9_6887_0000_0000, 64'h7fff_ffff_7fff_ffff
    };

    always #1 i_clk = ~i_clk;

    feistel_mix64 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word_in  (i_word_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word_out (o_word_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    feistel_mix64_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_word_in    (i_word_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_word_out   (o_word_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // output side: a fresh stall length after every accepted beat
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            n = rx_quiet ? 0 : $urandom_range(0, 4);
            i_stall    <= (n != 0);
            stall_left <= n;
        end else if (stall_left > 1) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end
    end

    task automatic send_word(input logic [63:0] w);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_word_in <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_pipe;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_mode(input logic m);
        reg_access(1'b1, ADDR_MIX_MODE, {31'($urandom_range(0, 32'h7fff_ffff)), m});
        reg_access(1'b1, ADDR_UNUSED, $urandom);
        reg_access(1'b0, ADDR_MIX_MODE, 32'h0);
    endtask

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        case ($urandom_range(0, 7))
            0:       w = 64'h1 << $urandom_range(0, 63);
            1:       w = ~(64'h1 << $urandom_range(0, 63));
            2:       w = {$urandom, $urandom} & {$urandom, $urandom};
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_word_in <= 64'h0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= 3'h0;
        pwdata    <= 32'h0;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of mix_mode first, then the multiply and hash rounds
        reg_access(1'b0, ADDR_MIX_MODE, 32'h0);
        foreach (edge_words[k]) send_word(edge_words[k]);
        drain_pipe();
        set_mode(MODE_JENKINS);
        foreach (edge_words[k]) send_word(edge_words[k]);
        drain_pipe();

        for (int p = 0; p < PHASES; p++) begin
            tx_quiet = (p == 1) || (p == 2);
            rx_quiet = (p == 1) || (p == 3);
            set_mode((p % 2 == 0) ? MODE_PSDES : MODE_JENKINS);
            for (int k = 0; k < PHASE_BEATS; k++) send_word(random_word());
            drain_pipe();
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
